/* hdl/ambient_light_led_dimmer_top_macros.svh */
// Assertion macros used by the checker file of the dimmer.
`ifndef AMBIENT_LIGHT_LED_DIMMER_TOP_MACROS_SVH
`define AMBIENT_LIGHT_LED_DIMMER_TOP_MACROS_SVH

// Checked only while the block is out of reset.
`define ALD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checked on every edge, reset included.
`define ALD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* hdl/ald_pkg.sv */
package ald_pkg;

    localparam int RAW_W        = 12;
    localparam int PCT_W        = 7;
    localparam int TS_W         = 32;
    localparam int Q8_W         = 16;
    localparam int ADC_BITS_DEF = 12;

    localparam int PCT_MAX     = 100;
    localparam int UPDATE_MS   = 50;
    localparam int ROUND_HALF  = 128;
    localparam int Q_SHIFT     = 8;
    // x / 100 equals (x * RECIP_100) >> RECIP_SHIFT for every x up to 10000.
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;

    localparam logic [RAW_W-1:0] MIN_RAW_RST      = 12'd0;
    localparam logic [RAW_W-1:0] MAX_RAW_RST      = 12'd4095;
    localparam logic [PCT_W-1:0] MIN_LED_RST      = 7'd0;
    localparam logic [PCT_W-1:0] MAX_LED_RST      = 7'd100;
    localparam logic             FIXED_MODE_RST   = 1'b0;
    localparam logic [PCT_W-1:0] FIXED_PCT_RST    = 7'd35;
    localparam logic [1:0]       FILTER_LEVEL_RST = 2'd2;
    localparam logic [1:0]       HYST_LEVEL_RST   = 2'd1;

    typedef enum logic [2:0] {
        REG_MIN_RAW      = 3'd0,
        REG_MAX_RAW      = 3'd1,
        REG_MIN_LED_PCT  = 3'd2,
        REG_MAX_LED_PCT  = 3'd3,
        REG_FIXED_MODE   = 3'd4,
        REG_FIXED_PCT    = 3'd5,
        REG_FILTER_LEVEL = 3'd6,
        REG_HYST_LEVEL   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_sample;
        logic [TS_W-1:0]  now_ms;
    } in_beat_t;

    typedef struct packed {
        logic [PCT_W-1:0] brightness_pct;
        logic [PCT_W-1:0] raw_pct;
        logic [PCT_W-1:0] mapped_pct;
    } out_beat_t;

    function automatic logic [PCT_W-1:0] clamp_pct(input logic [7:0] v);
        logic [PCT_W-1:0] r;
        r = (v > 8'(PCT_MAX)) ? PCT_W'(PCT_MAX) : v[PCT_W-1:0];
        return r;
    endfunction

    function automatic logic [2:0] filt_shift(input logic [1:0] level);
        logic [2:0] s;
        unique case (level)
            2'd0:    s = 3'd0;
            2'd1:    s = 3'd3;
            2'd2:    s = 3'd4;
            default: s = 3'd5;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] hyst_step(input logic [1:0] level);
        logic [2:0] s;
        unique case (level)
            2'd0:    s = 3'd0;
            2'd1:    s = 3'd2;
            2'd2:    s = 3'd4;
            default: s = 3'd6;
        endcase
        return s;
    endfunction

endpackage

/* hdl/ambient_light_led_dimmer_top.sv */
// Ambient-light LED dimmer.
// Input channel s_*: one beat carries an ADC light sample and a millisecond
// timestamp. Output channel m_*: one beat per input beat, carrying the LED
// brightness, the sample position in the raw range and the live mapped value.
// The APB port holds the eight setting registers; any write restarts the
// filter, so the next sensor-mode beat seeds it afresh.
// An accepted beat runs through a small sequencer: a setup step for the
// dividend, one saturation check and seven restoring-division steps on a
// shared compare-and-subtract unit, two multiply steps, a filter step and a
// hysteresis step, at whose end the result is registered. Only then does
// the sequencer return to idle, so it takes no new beat while one is still
// being handled.
// s_ready is high whenever the sequencer is idle, even while a result still
// waits on m_ready. If the receiver stalls, the next beat halts in its last
// cycle until the output register is free.
// Reset restores the register defaults, clears the filter state and leaves
// no result pending.
module ambient_light_led_dimmer_top #(
    parameter int ADC_BITS = ald_pkg::ADC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ald_pkg::in_beat_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ald_pkg::out_beat_t m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int WIDE_W = 17;
    localparam int SPAN_W = 13;
    localparam int NUM_W  = 19;
    localparam int PROD_W = 14;
    localparam int PCT_W  = ald_pkg::PCT_W;
    localparam int RAW_W  = ald_pkg::RAW_W;
    localparam int Q8_W   = ald_pkg::Q8_W;
    localparam int TS_W   = ald_pkg::TS_W;
    localparam logic [WIDE_W-1:0] ADC_MAX = WIDE_W'((1 << ADC_BITS) - 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SAT, ST_DIV, ST_MUL1, ST_MUL2, ST_FILT, ST_HOLD
    } state_t;

    state_t state_reg;

    logic [RAW_W-1:0] min_raw_reg, max_raw_reg;
    logic [PCT_W-1:0] min_led_reg, max_led_reg, fixed_pct_reg;
    logic             fixed_mode_reg;
    logic [1:0]       filter_level_reg, hyst_level_reg;

    logic [NUM_W-1:0]  rem_reg;
    logic [SPAN_W-1:0] span_reg;
    logic              zero_reg, sat_reg;
    logic [2:0]        cnt_reg;
    logic [PCT_W-1:0]  quo_reg, raw_pct_reg, live_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [TS_W-1:0]   now_reg, last_ms_reg;
    logic [Q8_W-1:0]   filt_q8_reg;
    logic              started_reg;
    logic [PCT_W-1:0]  held_reg;
    logic              m_valid_reg;
    ald_pkg::out_beat_t m_data_reg;

    // Register sanitising.
    logic [WIDE_W-1:0] hi_a, lo_a, hi_s, lo_s, raw_c;
    logic [PCT_W-1:0]  led_a, led_b, led_lo, led_hi;
    logic [RAW_W-1:0]  raw_diff;
    logic [NUM_W-1:0]  num_w;

    always_comb begin
        hi_a = WIDE_W'(max_raw_reg);
        if (hi_a > ADC_MAX) begin
            hi_a = ADC_MAX;
        end
        if (hi_a == '0) begin
            hi_a = WIDE_W'(1);
        end
        lo_a = WIDE_W'(min_raw_reg);
        if (lo_a > ADC_MAX - WIDE_W'(1)) begin
            lo_a = ADC_MAX - WIDE_W'(1);
        end
        hi_s = hi_a;
        lo_s = lo_a;
        if (lo_a >= hi_a) begin
            if (hi_a < ADC_MAX) begin
                hi_s = lo_a + WIDE_W'(1);
            end else begin
                lo_s = hi_a - WIDE_W'(1);
            end
        end
        raw_c = WIDE_W'(s_data.raw_sample);
        if (raw_c > ADC_MAX) begin
            raw_c = ADC_MAX;
        end
        raw_diff = RAW_W'(raw_c - lo_s);
        // Times 100 as shifts and adds: 64 + 32 + 4.
        num_w = (NUM_W'(raw_diff) << 6) + (NUM_W'(raw_diff) << 5)
              + (NUM_W'(raw_diff) << 2);

        led_a = ald_pkg::clamp_pct(8'(min_led_reg));
        led_b = ald_pkg::clamp_pct(8'(max_led_reg));
        if (led_a > led_b) begin
            led_lo = led_b;
            led_hi = led_a;
        end else begin
            led_lo = led_a;
            led_hi = led_b;
        end
    end

    // Shared compare-and-subtract unit for the division steps.
    logic [NUM_W-1:0] div_sub;
    logic             div_ge;
    assign div_sub = NUM_W'(span_reg) << cnt_reg;
    assign div_ge  = rem_reg >= div_sub;

    logic [PCT_W-1:0] pct_w;
    always_comb begin
        if (zero_reg) begin
            pct_w = '0;
        end else if (sat_reg) begin
            pct_w = PCT_W'(ald_pkg::PCT_MAX);
        end else begin
            pct_w = ald_pkg::clamp_pct(8'(quo_reg));
        end
    end

    logic [26:0]      recip_prod;
    logic [PCT_W-1:0] live_w;
    assign recip_prod = 27'(prod_reg) * 27'(ald_pkg::RECIP_100);
    assign live_w = ald_pkg::clamp_pct(8'(led_lo)
                                       + 8'(recip_prod >> ald_pkg::RECIP_SHIFT));

    // Exponential average step.
    logic [Q8_W-1:0] target_q8, up_q8, down_q8, dn_diff, round_mask;
    logic [TS_W-1:0] elapsed;
    logic [2:0]      shift_s;
    always_comb begin
        target_q8  = Q8_W'(live_reg) << ald_pkg::Q_SHIFT;
        elapsed    = now_reg - last_ms_reg;
        shift_s    = ald_pkg::filt_shift(filter_level_reg);
        round_mask = (Q8_W'(1) << shift_s) - Q8_W'(1);
        up_q8      = filt_q8_reg + ((target_q8 - filt_q8_reg) >> shift_s);
        dn_diff    = filt_q8_reg - target_q8;
        down_q8    = filt_q8_reg - ((dn_diff + round_mask) >> shift_s);
    end

    // Rounding and hysteresis.
    logic [Q8_W:0]    round_sum;
    logic [PCT_W-1:0] rounded, hyst_diff, held_w;
    logic [2:0]       step_s;
    always_comb begin
        round_sum = (Q8_W+1)'(filt_q8_reg) + (Q8_W+1)'(ald_pkg::ROUND_HALF);
        rounded   = ald_pkg::clamp_pct(8'(round_sum >> ald_pkg::Q_SHIFT));
        hyst_diff = (rounded >= held_reg) ? rounded - held_reg : held_reg - rounded;
        step_s    = ald_pkg::hyst_step(hyst_level_reg);
        held_w    = held_reg;
        if (step_s == 3'd0 || hyst_diff >= PCT_W'(step_s)) begin
            held_w = rounded;
        end
    end

    logic cfg_wr;
    ald_pkg::cfg_idx_t cfg_idx;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = ald_pkg::cfg_idx_t'(paddr[4:2]);

    // The output register takes a new beat when it is empty or being emptied.
    logic out_load;
    assign out_load = (state_reg == ST_HOLD) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            started_reg      <= 1'b0;
            last_ms_reg      <= '0;
            filt_q8_reg      <= '0;
            held_reg         <= '0;
            min_raw_reg      <= ald_pkg::MIN_RAW_RST;
            max_raw_reg      <= ald_pkg::MAX_RAW_RST;
            min_led_reg      <= ald_pkg::MIN_LED_RST;
            max_led_reg      <= ald_pkg::MAX_LED_RST;
            fixed_mode_reg   <= ald_pkg::FIXED_MODE_RST;
            fixed_pct_reg    <= ald_pkg::FIXED_PCT_RST;
            filter_level_reg <= ald_pkg::FILTER_LEVEL_RST;
            hyst_level_reg   <= ald_pkg::HYST_LEVEL_RST;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        rem_reg   <= num_w;
                        span_reg  <= SPAN_W'(hi_s - lo_s);
                        zero_reg  <= raw_c <= lo_s;
                        now_reg   <= s_data.now_ms;
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    // A quotient of 128 or more saturates straight to 100.
                    sat_reg   <= {1'b0, rem_reg} >= {span_reg, 7'b0};
                    quo_reg   <= '0;
                    cnt_reg   <= 3'd6;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_ge) begin
                        rem_reg          <= rem_reg - div_sub;
                        quo_reg[cnt_reg] <= 1'b1;
                    end
                    if (cnt_reg == 3'd0) begin
                        state_reg <= ST_MUL1;
                    end else begin
                        cnt_reg <= cnt_reg - 3'd1;
                    end
                end
                ST_MUL1: begin
                    raw_pct_reg <= pct_w;
                    prod_reg    <= PROD_W'(pct_w) * PROD_W'(led_hi - led_lo);
                    state_reg   <= ST_MUL2;
                end
                ST_MUL2: begin
                    live_reg  <= live_w;
                    state_reg <= ST_FILT;
                end
                ST_FILT: begin
                    if (!fixed_mode_reg) begin
                        if (!started_reg) begin
                            // Seeding leaves the hysteresis stage with nothing to do.
                            started_reg <= 1'b1;
                            last_ms_reg <= now_reg;
                            filt_q8_reg <= target_q8;
                            held_reg    <= live_reg;
                        end else if (elapsed >= TS_W'(ald_pkg::UPDATE_MS)) begin
                            last_ms_reg <= now_reg;
                            if (shift_s == 3'd0) begin
                                filt_q8_reg <= target_q8;
                            end else if (target_q8 >= filt_q8_reg) begin
                                filt_q8_reg <= up_q8;
                            end else begin
                                filt_q8_reg <= down_q8;
                            end
                        end
                    end
                    state_reg <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (out_load) begin
                        if (fixed_mode_reg) begin
                            m_data_reg.brightness_pct <=
                                ald_pkg::clamp_pct(8'(fixed_pct_reg));
                        end else begin
                            held_reg                  <= held_w;
                            m_data_reg.brightness_pct <= held_w;
                        end
                        m_data_reg.raw_pct    <= raw_pct_reg;
                        m_data_reg.mapped_pct <= live_reg;
                        state_reg             <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (cfg_wr) begin
                started_reg <= 1'b0;
                unique case (cfg_idx)
                    ald_pkg::REG_MIN_RAW:      min_raw_reg      <= pwdata[RAW_W-1:0];
                    ald_pkg::REG_MAX_RAW:      max_raw_reg      <= pwdata[RAW_W-1:0];
                    ald_pkg::REG_MIN_LED_PCT:  min_led_reg      <= pwdata[PCT_W-1:0];
                    ald_pkg::REG_MAX_LED_PCT:  max_led_reg      <= pwdata[PCT_W-1:0];
                    ald_pkg::REG_FIXED_MODE:   fixed_mode_reg   <= pwdata[0];
                    ald_pkg::REG_FIXED_PCT:    fixed_pct_reg    <= pwdata[PCT_W-1:0];
                    ald_pkg::REG_FILTER_LEVEL: filter_level_reg <= pwdata[1:0];
                    ald_pkg::REG_HYST_LEVEL:   hyst_level_reg   <= pwdata[1:0];
                    default:                   ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (cfg_idx)
            ald_pkg::REG_MIN_RAW:      prdata = 32'(min_raw_reg);
            ald_pkg::REG_MAX_RAW:      prdata = 32'(max_raw_reg);
            ald_pkg::REG_MIN_LED_PCT:  prdata = 32'(min_led_reg);
            ald_pkg::REG_MAX_LED_PCT:  prdata = 32'(max_led_reg);
            ald_pkg::REG_FIXED_MODE:   prdata = 32'(fixed_mode_reg);
            ald_pkg::REG_FIXED_PCT:    prdata = 32'(fixed_pct_reg);
            ald_pkg::REG_FILTER_LEVEL: prdata = 32'(filter_level_reg);
            ald_pkg::REG_HYST_LEVEL:   prdata = 32'(hyst_level_reg);
            default:                   prdata = '0;
        endcase
    end

    assign pready  = 1'b1;
    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* hdl/ald_checker.sv */
`include "ambient_light_led_dimmer_top_macros.svh"

module ald_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input ald_pkg::out_beat_t m_data
);

    `ALD_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid, "result beat dropped while stalled")
    `ALD_ASSERT(a_out_stable, m_valid && !m_ready |=> $stable(m_data), "stalled result beat changed")
    `ALD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result pending after reset")
    `ALD_ASSERT(a_pct_range, m_valid |-> m_data.brightness_pct <= 7'd100 && m_data.raw_pct <= 7'd100 && m_data.mapped_pct <= 7'd100, "percent above 100")
    `ALD_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "input taken while busy")

endmodule

bind ambient_light_led_dimmer_top ald_checker u_ald_checker (.*);
